// ===== rtl/ugr_pkg.sv =====
// shared constants and types for the utf-8 glyph row renderer
// sizes of the glyph table and bitmap store, function and register codes, fsm states
// no dependencies

package ugr_pkg;

    localparam int MAX_GLYPHS   = 256;
    localparam int BITMAP_BYTES = 8192;
    localparam int MAX_DIM      = 16;

    localparam int GLYPH_AW  = $clog2(MAX_GLYPHS);
    localparam int BITMAP_AW = $clog2(BITMAP_BYTES);
    // bitmap address sums keep one spare bit so the range test sees overflow
    localparam int BADDR_W   = BITMAP_AW + 1;

    localparam int CODE_W  = 16;
    localparam int WIDTH_W = 5;
    localparam int COUNT_W = 9;
    localparam int ENTRY_W = CODE_W + WIDTH_W;

    typedef enum logic [1:0] {
        FUNC_LOAD_GLYPH  = 2'd0,
        FUNC_LOAD_BITMAP = 2'd1,
        FUNC_RENDER      = 2'd2,
        FUNC_NONE        = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_GLYPH_WIDTH  = 2'd0,
        CFG_GLYPH_HEIGHT = 2'd1,
        CFG_GLYPH_COUNT  = 2'd2,
        CFG_SPARE        = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_BASE,
        ST_RD0,
        ST_RD1,
        ST_EMIT,
        ST_ERR
    } state_t;

endpackage

// ===== rtl/utf8_glyph_row_renderer.sv =====
// utf-8 character generator: glyph table and bitmap store in synchronous ram
// decodes a lead byte, searches the table, streams one transaction per glyph row
// depends on ugr_pkg
//
//  channel   signals                         direction  carries
//  s_        s_tvalid s_tready s_tdata s_tuser  in      load and render commands
//  m_        m_tvalid m_tready m_tdata m_tlast m_tuser out  glyph rows or error
//  cfg_      cfg_we cfg_index cfg_data          in      cell width, height, entry count
//
// a load writes its ram as it is accepted. a render decodes the character, then scans the glyph
// table one entry per cycle through its single read port until a hit or the last counted entry,
// forms the glyph base, and reads two bytes per row through the bitmap port.
// reset clears control state only; the rams are not cleared.
// a stalled output holds its register and the row sequencer waits; the next command is
// accepted as soon as the last row of a render sits in the output register.

module utf8_glyph_row_renderer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_addr[12:0] entry_code[28:13] entry_width[33:29] bitmap_byte[41:34]
    // utf_byte0[49:42] utf_byte1[57:50] utf_byte2[65:58] utf_byte3[73:66], zero pad
    input  logic [79:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row_bits[15:0] row_width[20:16], zero pad
    output logic [23:0] m_tdata,
    // last_row
    output logic        m_tlast,
    // status[0]
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [ugr_pkg::WIDTH_W-1:0] DIM_MAX = ugr_pkg::WIDTH_W'(ugr_pkg::MAX_DIM);
    localparam logic [ugr_pkg::COUNT_W-1:0] N_MAX   = ugr_pkg::COUNT_W'(ugr_pkg::MAX_GLYPHS);

    // input fields
    logic [12:0]                  load_addr;
    logic [ugr_pkg::CODE_W-1:0]   entry_code;
    logic [ugr_pkg::WIDTH_W-1:0]  entry_width;
    logic [7:0]                   bitmap_byte;
    logic [7:0]                   utf0;
    logic [7:0]                   utf1;
    logic [7:0]                   utf2;
    logic [7:0]                   utf3;
    ugr_pkg::func_t               func;

    assign load_addr   = s_tdata[12:0];
    assign entry_code  = s_tdata[28:13];
    assign entry_width = s_tdata[33:29];
    assign bitmap_byte = s_tdata[41:34];
    assign utf0        = s_tdata[49:42];
    assign utf1        = s_tdata[57:50];
    assign utf2        = s_tdata[65:58];
    assign utf3        = s_tdata[73:66];
    assign func        = ugr_pkg::func_t'(s_tuser);

    // configuration
    logic [4:0] glyph_width_reg;
    logic [4:0] glyph_height_reg;
    logic [8:0] glyph_count_reg;

    // control
    ugr_pkg::state_t              state_reg, state_next;
    logic [ugr_pkg::COUNT_W-1:0]  idx_reg;
    logic                         chk_valid_reg;
    logic [4:0]                   y_reg;
    logic                         m_tvalid_reg;

    // payload
    logic [ugr_pkg::CODE_W-1:0]   cp_reg;
    logic [ugr_pkg::GLYPH_AW-1:0] chk_idx_reg;
    logic [ugr_pkg::GLYPH_AW-1:0] found_reg;
    logic [4:0]                   dw_reg;
    logic [5:0]                   gstride_reg;
    logic [ugr_pkg::BADDR_W-1:0]  row_addr_reg;
    logic [7:0]                   byte0_reg;
    logic [15:0]                  row_bits_reg;
    logic [4:0]                   row_width_reg;
    logic                         m_tlast_reg;
    logic                         m_tuser_reg;

    // rams
    logic [ugr_pkg::ENTRY_W-1:0]  glyph_mem [ugr_pkg::MAX_GLYPHS];
    logic [7:0]                   bitmap_mem [ugr_pkg::BITMAP_BYTES];
    logic [ugr_pkg::ENTRY_W-1:0]  glyph_rd_reg;
    logic [7:0]                   bm_rd_reg;
    logic                         bm_ok_reg;

    // combinational
    logic                         s_accept;
    logic                         glyph_we;
    logic                         bitmap_we;
    logic [ugr_pkg::CODE_W-1:0]   cp_dec;
    logic [ugr_pkg::COUNT_W-1:0]  n_entries;
    logic                         issue;
    logic                         hit;
    logic [4:0]                   cw;
    logic [4:0]                   ch;
    logic [8:0]                   cell_sum;
    logic [4:0]                   rstride_sum;
    logic [1:0]                   row_stride;
    logic [ugr_pkg::BADDR_W-1:0]  bm_raddr;
    logic [7:0]                   bm_byte;
    logic [4:0]                   hit_width;
    logic                         out_free;
    logic                         last;
    logic                         push_row;
    logic                         push_err;
    logic [15:0]                  row_mask;

    function automatic logic [15:0] decode_utf8(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3
    );
        logic [15:0] cp;
        begin
            if (b0 <= 8'h7F)
            begin
                cp = {8'h00, b0};
            end
            else if (b0 >= 8'hC0 && b0 <= 8'hDF)
            begin
                cp = {5'b0, b0 & 8'h1F, 3'b0} | {10'b0, b1[5:0]};
                cp = {5'b0, b0[4:0], b1[5:0]};
            end
            else if (b0 >= 8'hE0 && b0 <= 8'hEF)
            begin
                cp = {b0[3:0], b1[5:0], b2[5:0]};
            end
            else if (b0 >= 8'hF0 && b0 <= 8'hF7)
            begin
                // the 21-bit value kept to its low 16 bits
                cp = {b1[3:0], b2[5:0], b3[5:0]};
            end
            else
            begin
                cp = 16'h0000;
            end
            return cp;
        end
    endfunction

    assign s_accept  = s_tvalid && s_tready;
    assign glyph_we  = s_accept && func == ugr_pkg::FUNC_LOAD_GLYPH
                       && 32'(load_addr) < ugr_pkg::MAX_GLYPHS;
    assign bitmap_we = s_accept && func == ugr_pkg::FUNC_LOAD_BITMAP
                       && 32'(load_addr) < ugr_pkg::BITMAP_BYTES;
    assign cp_dec    = decode_utf8(utf0, utf1, utf2, utf3);

    assign n_entries = (glyph_count_reg > N_MAX) ? N_MAX : glyph_count_reg;
    assign issue     = idx_reg < n_entries;
    assign hit       = chk_valid_reg && glyph_rd_reg[ugr_pkg::CODE_W-1:0] == cp_reg;
    assign hit_width = (glyph_rd_reg[ugr_pkg::ENTRY_W-1:ugr_pkg::CODE_W] > DIM_MAX)
                       ? DIM_MAX : glyph_rd_reg[ugr_pkg::ENTRY_W-1:ugr_pkg::CODE_W];

    assign cw          = (glyph_width_reg > DIM_MAX) ? DIM_MAX : glyph_width_reg;
    assign ch          = (glyph_height_reg > DIM_MAX) ? DIM_MAX : glyph_height_reg;
    assign cell_sum    = 9'(cw * ch) + 9'd7;
    assign rstride_sum = cw + 5'd7;
    assign row_stride  = rstride_sum[4:3];

    // second byte of a row is read in every state but the first read
    assign bm_raddr = row_addr_reg
                      + ugr_pkg::BADDR_W'(state_reg == ugr_pkg::ST_RD0 ? 1'b0 : 1'b1);
    assign bm_byte  = bm_ok_reg ? bm_rd_reg : 8'h00;
    assign row_mask = ~(16'hFFFF >> dw_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign last     = (y_reg + 5'd1) == ch;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ugr_pkg::ST_IDLE:
            begin
                if (s_accept && func == ugr_pkg::FUNC_RENDER)
                begin
                    state_next = (cp_dec == 16'h0000) ? ugr_pkg::ST_ERR : ugr_pkg::ST_SEARCH;
                end
            end
            ugr_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    state_next = ugr_pkg::ST_BASE;
                end
                else if (!issue && !chk_valid_reg)
                begin
                    state_next = ugr_pkg::ST_ERR;
                end
            end
            ugr_pkg::ST_BASE:
            begin
                state_next = (ch == 5'd0) ? ugr_pkg::ST_IDLE : ugr_pkg::ST_RD0;
            end
            ugr_pkg::ST_RD0:
            begin
                state_next = ugr_pkg::ST_RD1;
            end
            ugr_pkg::ST_RD1:
            begin
                state_next = ugr_pkg::ST_EMIT;
            end
            ugr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last ? ugr_pkg::ST_IDLE : ugr_pkg::ST_RD0;
                end
            end
            ugr_pkg::ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ugr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ugr_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        push_row = 1'b0;
        push_err = 1'b0;
        unique case (state_reg)
            ugr_pkg::ST_IDLE: s_tready = 1'b1;
            ugr_pkg::ST_EMIT: push_row = out_free;
            ugr_pkg::ST_ERR:  push_err = out_free;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // glyph table ram
    always_ff @(posedge clk)
    begin
        glyph_rd_reg <= glyph_mem[idx_reg[ugr_pkg::GLYPH_AW-1:0]];
        if (glyph_we)
        begin
            glyph_mem[load_addr[ugr_pkg::GLYPH_AW-1:0]] <= {entry_width, entry_code};
        end
    end

    // bitmap ram
    always_ff @(posedge clk)
    begin
        bm_rd_reg <= bitmap_mem[bm_raddr[ugr_pkg::BITMAP_AW-1:0]];
        bm_ok_reg <= 32'(bm_raddr) < ugr_pkg::BITMAP_BYTES;
        if (bitmap_we)
        begin
            bitmap_mem[load_addr[ugr_pkg::BITMAP_AW-1:0]] <= bitmap_byte;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ugr_pkg::ST_IDLE;
            idx_reg          <= '0;
            chk_valid_reg    <= 1'b0;
            y_reg            <= 5'd0;
            m_tvalid_reg     <= 1'b0;
            glyph_width_reg  <= 5'd8;
            glyph_height_reg <= 5'd16;
            glyph_count_reg  <= 9'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (ugr_pkg::cfg_idx_t'(cfg_index))
                    ugr_pkg::CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[4:0];
                    ugr_pkg::CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[4:0];
                    ugr_pkg::CFG_GLYPH_COUNT:  glyph_count_reg  <= cfg_data;
                    default:
                    begin
                        glyph_count_reg <= glyph_count_reg;
                    end
                endcase
            end

            if (s_accept)
            begin
                idx_reg       <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (state_reg == ugr_pkg::ST_SEARCH)
            begin
                chk_valid_reg <= !hit && issue;
                if (!hit && issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            else
            begin
                chk_valid_reg <= 1'b0;
            end

            if (state_reg == ugr_pkg::ST_BASE)
            begin
                y_reg <= 5'd0;
            end
            else if (push_row)
            begin
                y_reg <= y_reg + 5'd1;
            end

            if (push_row || push_err)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        gstride_reg <= cell_sum[8:3];
        if (s_accept)
        begin
            cp_reg <= cp_dec;
        end
        if (state_reg == ugr_pkg::ST_SEARCH)
        begin
            chk_idx_reg <= idx_reg[ugr_pkg::GLYPH_AW-1:0];
            if (hit)
            begin
                found_reg <= chk_idx_reg;
                dw_reg    <= hit_width;
            end
        end
        if (state_reg == ugr_pkg::ST_BASE)
        begin
            row_addr_reg <= ugr_pkg::BADDR_W'(found_reg * gstride_reg);
        end
        else if (push_row)
        begin
            row_addr_reg <= row_addr_reg + ugr_pkg::BADDR_W'(row_stride);
        end
        if (state_reg == ugr_pkg::ST_RD1)
        begin
            byte0_reg <= bm_byte;
        end
        if (push_row)
        begin
            row_bits_reg  <= {byte0_reg, bm_byte} & row_mask;
            row_width_reg <= dw_reg;
            m_tlast_reg   <= last;
            m_tuser_reg   <= 1'b0;
        end
        else if (push_err)
        begin
            row_bits_reg  <= 16'h0000;
            row_width_reg <= 5'd0;
            m_tlast_reg   <= 1'b1;
            m_tuser_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, row_width_reg, row_bits_reg};
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // a compared entry always lies inside the searched range
    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ugr_pkg::ST_SEARCH && chk_valid_reg)
            |-> ugr_pkg::COUNT_W'(chk_idx_reg) < n_entries)
        else $error("compared glyph entry beyond searched range");

    // a render goes straight to the scan or to the error result
    a_render_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && func == ugr_pkg::FUNC_RENDER)
            |=> (state_reg == ugr_pkg::ST_SEARCH || state_reg == ugr_pkg::ST_ERR))
        else $error("render did not start search or error");

    // the row counter never passes the glyph height
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ugr_pkg::ST_EMIT) |-> y_reg < ch)
        else $error("row counter beyond glyph height");

    // output becomes valid only from a row or error push
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg)
            |-> ($past(state_reg) == ugr_pkg::ST_EMIT || $past(state_reg) == ugr_pkg::ST_ERR))
        else $error("output valid without a push");

endmodule

// ===== tb/tb.sv =====
// testbench for utf8_glyph_row_renderer: fills the font, renders characters and
// checks every row transaction against a built-in glyph row predictor
// depends on ugr_pkg and the renderer rtl
`timescale 1ns / 1ps

module tb;

    import ugr_pkg::*;

    localparam int  CYCLE_LIMIT = 2000000;
    // long enough for a render with a full table scan and no rows to finish
    localparam int  HOLD_CYCLES = 400;
    localparam logic ROW_OK     = 1'b0;
    localparam logic ROW_ERR    = 1'b1;

    typedef struct {
        func_t       fn;
        logic [12:0] addr;
        logic [15:0] code;
        logic [4:0]  ewid;
        logic [7:0]  pix;
        logic [7:0]  u0;
        logic [7:0]  u1;
        logic [7:0]  u2;
        logic [7:0]  u3;
    } cmd_t;

    typedef struct {
        logic [15:0] bits;
        logic [4:0]  wid;
        logic        last;
        logic        status;
    } row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = FUNC_NONE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data  = '0;

    // predictor state
    logic [15:0] glyph_code [MAX_GLYPHS];
    logic [4:0]  glyph_wid  [MAX_GLYPHS];
    logic [7:0]  pix_store  [BITMAP_BYTES];
    bit          pix_valid  [BITMAP_BYTES];
    logic [4:0]  cell_w      = 5'd8;
    logic [4:0]  cell_h      = 5'd16;
    logic [8:0]  glyph_limit = 9'd0;

    row_t expected_rows [$];

    int fail_count   = 0;
    int rows_checked = 0;
    int renders      = 0;
    int loads        = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    bit quiet        = 1'b0;

    utf8_glyph_row_renderer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows outstanding",
                     cycle_count, expected_rows.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (quiet)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_rows
        row_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            rows_checked++;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row transaction: row_bits %h status %b",
                       m_tdata[15:0], m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (m_tdata[15:0] !== want.bits)
                begin
                    $error("row_bits: expected %h, got %h", want.bits, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[20:16] !== want.wid)
                begin
                    $error("row_width: expected %0d, got %0d", want.wid, m_tdata[20:16]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_row: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [15:0] decode_char(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [7:0] b3);
        logic [20:0] cp;
        if (b0 <= 8'h7F)
            cp = {13'd0, b0};
        else if (b0 >= 8'hC0 && b0 <= 8'hDF)
            cp = {10'd0, b0[4:0], b1[5:0]};
        else if (b0 >= 8'hE0 && b0 <= 8'hEF)
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        else if (b0 >= 8'hF0 && b0 <= 8'hF7)
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        else
            cp = '0;
        return cp[15:0];
    endfunction

    // random utf-8 form that decodes to cp, spare bits random; returns {u3, u2, u1, u0}
    function automatic logic [31:0] encode_char(input logic [15:0] cp);
        logic [7:0] b [4];
        int form;
        for (int i = 0; i < 4; i++)
            b[i] = 8'($urandom);
        if (cp <= 16'h007F)
            form = $urandom_range(0, 3);
        else if (cp < 16'h0800)
            form = $urandom_range(1, 3);
        else
            form = $urandom_range(2, 3);
        case (form)
            0: b[0] = {1'b0, cp[6:0]};
            1:
            begin
                b[0] = {3'b110, cp[10:6]};
                b[1][5:0] = cp[5:0];
            end
            2:
            begin
                b[0] = {4'b1110, cp[15:12]};
                b[1][5:0] = cp[11:6];
                b[2][5:0] = cp[5:0];
            end
            default:
            begin
                // bits above 16 of the 21-bit value stay random
                b[0] = {5'b11110, b[0][2:0]};
                b[1][3:0] = cp[15:12];
                b[2][5:0] = cp[11:6];
                b[3][5:0] = cp[5:0];
            end
        endcase
        return {b[3], b[2], b[1], b[0]};
    endfunction

    function automatic int find_glyph(input logic [15:0] cp);
        int n;
        n = (glyph_limit > MAX_GLYPHS) ? MAX_GLYPHS : int'(glyph_limit);
        for (int i = 0; i < n; i++)
            if (glyph_code[i] == cp)
                return i;
        return -1;
    endfunction

    function automatic void glyph_geometry(input int hit, output int base, output int stride,
                                           output int rows);
        int cw;
        int ch;
        cw = (cell_w > MAX_DIM) ? MAX_DIM : int'(cell_w);
        ch = (cell_h > MAX_DIM) ? MAX_DIM : int'(cell_h);
        rows = ch;
        stride = (cw + 7) / 8;
        base = hit * ((cw * ch + 7) / 8);
    endfunction

    function automatic void predict_glyph_rows(input cmd_t c);
        logic [15:0] cp;
        logic [15:0] bits;
        logic [7:0]  b;
        int hit;
        int base;
        int stride;
        int rows;
        int dw;
        int a;
        cp = decode_char(c.u0, c.u1, c.u2, c.u3);
        hit = (cp == 16'h0000) ? -1 : find_glyph(cp);
        if (hit < 0)
        begin
            expected_rows.push_back('{16'h0000, 5'd0, 1'b1, ROW_ERR});
            return;
        end
        glyph_geometry(hit, base, stride, rows);
        dw = (glyph_wid[hit] > 16) ? 16 : int'(glyph_wid[hit]);
        for (int y = 0; y < rows; y++)
        begin
            bits = '0;
            for (int x = 0; x < dw; x++)
            begin
                a = base + y * stride + x / 8;
                b = (a < BITMAP_BYTES) ? pix_store[a] : 8'h00;
                if (b[7 - x % 8])
                    bits[15 - x] = 1'b1;
            end
            expected_rows.push_back('{bits, 5'(dw), (y == rows - 1), ROW_OK});
        end
    endfunction

    function automatic void update_font(input cmd_t c);
        case (c.fn)
            FUNC_LOAD_GLYPH:
            begin
                if (c.addr < MAX_GLYPHS)
                begin
                    glyph_code[c.addr] = c.code;
                    glyph_wid[c.addr] = c.ewid;
                end
            end
            FUNC_LOAD_BITMAP:
            begin
                pix_store[c.addr] = c.pix;
                pix_valid[c.addr] = 1'b1;
            end
            FUNC_RENDER: predict_glyph_rows(c);
            default: ;
        endcase
    endfunction

    function automatic cmd_t rand_cmd(input func_t fn);
        cmd_t c;
        c.fn   = fn;
        c.addr = 13'($urandom);
        c.code = 16'($urandom);
        c.ewid = 5'($urandom);
        c.pix  = 8'($urandom);
        c.u0   = 8'($urandom);
        c.u1   = 8'($urandom);
        c.u2   = 8'($urandom);
        c.u3   = 8'($urandom);
        return c;
    endfunction

    // small codes repeat often, so the table holds duplicates and renders hit
    function automatic logic [15:0] pick_code();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(1, 200));
        return 16'($urandom);
    endfunction

    task automatic send_item(input cmd_t c);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.fn;
        s_tdata  <= {6'd0, c.u3, c.u2, c.u1, c.u0, c.pix, c.ewid, c.code, c.addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        update_font(c);
        if (c.fn == FUNC_RENDER)
            renders++;
        else if (c.fn != FUNC_NONE)
            loads++;
    endtask

    // write every bitmap byte the render may fetch, two per row, before sending it
    task automatic send_render(input cmd_t c);
        cmd_t ld;
        logic [15:0] cp;
        int hit;
        int base;
        int stride;
        int rows;
        int a;
        cp = decode_char(c.u0, c.u1, c.u2, c.u3);
        hit = (cp == 16'h0000) ? -1 : find_glyph(cp);
        if (hit >= 0)
        begin
            glyph_geometry(hit, base, stride, rows);
            for (int y = 0; y < rows; y++)
                for (int k = 0; k < 2; k++)
                begin
                    a = base + y * stride + k;
                    if (a < BITMAP_BYTES && !pix_valid[a])
                    begin
                        ld = rand_cmd(FUNC_LOAD_BITMAP);
                        ld.addr = 13'(a);
                        send_item(ld);
                    end
                end
        end
        send_item(c);
    endtask

    task automatic render_bytes(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] b3);
        cmd_t c;
        c = rand_cmd(FUNC_RENDER);
        c.u0 = b0;
        c.u1 = b1;
        c.u2 = b2;
        c.u3 = b3;
        send_render(c);
    endtask

    task automatic load_glyph(input logic [12:0] idx, input logic [15:0] code,
                              input logic [4:0] w);
        cmd_t c;
        c = rand_cmd(FUNC_LOAD_GLYPH);
        c.addr = idx;
        c.code = code;
        c.ewid = w;
        send_item(c);
    endtask

    // drop valid, let every row arrive, then give the block time to finish silent work
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_GLYPH_WIDTH:  cell_w = val[4:0];
            CFG_GLYPH_HEIGHT: cell_h = val[4:0];
            CFG_GLYPH_COUNT:  glyph_limit = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [4:0] w, input logic [4:0] h,
                                input logic [8:0] cnt);
        settle_block();
        // upper data bits of the 5-bit registers are junk and must be dropped
        write_reg(CFG_GLYPH_WIDTH, {4'($urandom), w});
        write_reg(CFG_GLYPH_HEIGHT, {4'($urandom), h});
        write_reg(CFG_GLYPH_COUNT, cnt);
        write_reg(CFG_SPARE, 9'($urandom));
    endtask

    task automatic run_traffic(input int n_items);
        cmd_t c;
        int pick;
        int lim;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            c = rand_cmd(FUNC_RENDER);
            lim = (glyph_limit > MAX_GLYPHS) ? MAX_GLYPHS : int'(glyph_limit);
            if (pick < 55)
            begin
                if (lim > 0)
                    {c.u3, c.u2, c.u1, c.u0} = encode_char(glyph_code[$urandom_range(0, lim - 1)]);
            end
            else if (pick < 65)
            begin
                {c.u3, c.u2, c.u1, c.u0} = encode_char(pick_code());
            end
            else if (pick < 75)
            begin
                // raw bytes: invalid leads, zero and misses
            end
            else if (pick < 85)
            begin
                c.fn = FUNC_LOAD_GLYPH;
                c.code = pick_code();
                if ($urandom_range(0, 4) != 0)
                    c.addr = 13'($urandom_range(0, MAX_GLYPHS - 1));
            end
            else if (pick < 95)
            begin
                c.fn = FUNC_LOAD_BITMAP;
            end
            else
            begin
                c.fn = FUNC_NONE;
            end
            if (c.fn == FUNC_RENDER)
                send_render(c);
            else
                send_item(c);
            if (c.fn != FUNC_NONE)
                sent++;
        end
    endtask

    // every table entry gets written before any search can touch it
    task automatic test_font_table();
        cmd_t c;
        for (int i = 0; i < MAX_GLYPHS; i++)
        begin
            c = rand_cmd(FUNC_LOAD_GLYPH);
            c.addr = 13'(i);
            c.code = pick_code();
            send_item(c);
        end
    endtask

    // glyph count is still zero from reset, so every valid character misses
    task automatic test_bad_characters();
        cmd_t c;
        render_bytes(8'h41, 8'h80, 8'h80, 8'h80);
        render_bytes(8'h00, 8'hFF, 8'hFF, 8'hFF);
        render_bytes(8'h80, 8'hBF, 8'hBF, 8'hBF);
        render_bytes(8'hBF, 8'h00, 8'h00, 8'h00);
        render_bytes(8'hF8, 8'h80, 8'h80, 8'h80);
        render_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        c = rand_cmd(FUNC_NONE);
        send_item(c);
    endtask

    task automatic test_lookup();
        load_glyph(13'd0, 16'h0041, 5'd8);
        load_glyph(13'd1, 16'h03A9, 5'd16);
        load_glyph(13'd2, 16'h20AC, 5'd31);
        load_glyph(13'd3, 16'hF600, 5'd0);
        load_glyph(13'd4, 16'hFFFF, 5'd5);
        // duplicate code: the lower entry must win
        load_glyph(13'd5, 16'h0041, 5'd3);
        // out of range indexes must not alias onto entries 0 and 255
        load_glyph(13'd256, 16'h0000, 5'd0);
        load_glyph(13'd8191, 16'h0000, 5'd31);
        settle_block();
        write_reg(CFG_GLYPH_COUNT, 9'd6);
        render_bytes(8'h41, 8'h00, 8'h00, 8'h00);
        render_bytes(8'hCE, 8'hA9, 8'h00, 8'h00);
        render_bytes(8'hE2, 8'h82, 8'hAC, 8'h00);
        render_bytes(8'hF0, 8'h9F, 8'h98, 8'h80);
        render_bytes(8'hEF, 8'hBF, 8'hBF, 8'hFF);
        render_bytes(8'hC0, 8'h80, 8'h00, 8'h00);
        render_bytes(8'h7F, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_cell_extremes();
        set_geometry(5'd0, 5'd0, 9'd40);
        run_traffic(25);
        set_geometry(5'd1, 5'd1, 9'd1);
        run_traffic(25);
        set_geometry(5'd31, 5'd31, 9'd511);
        run_traffic(40);
        set_geometry(5'd16, 5'd16, 9'd256);
        run_traffic(50);
        set_geometry(5'd17, 5'd3, 9'd257);
        run_traffic(25);
    endtask

    task automatic test_random_traffic();
        repeat (3)
        begin
            set_geometry(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                         9'($urandom_range(0, 256)));
            run_traffic(35);
        end
        set_geometry(5'd9, 5'd3, 9'd0);
        run_traffic(15);
        // closing stretch with both sides streaming flat out
        quiet = 1'b1;
        set_geometry(5'd8, 5'd16, 9'd256);
        run_traffic(40);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_font_table();
        test_bad_characters();
        test_lookup();
        test_cell_extremes();
        test_random_traffic();
        settle_block();
        $display("%0d renders and %0d loads accepted, %0d row transactions checked in %0d cycles",
                 renders, loads, rows_checked, cycle_count);
        $display("cells from zero to oversized, glyph counts from zero to 511, stalls on both sides");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ugr_pkg.sv
rtl/utf8_glyph_row_renderer.sv
tb/tb.sv
